>>> rtl/core/spa_pkg.sv
`default_nettype none

package spa_pkg;

    // field widths
    localparam int REQ_W       = 2;
    localparam int COEF_W      = 16;
    localparam int EXP_W       = 8;
    localparam int SUM_W       = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - EXP_W;

    // request codes on the input tuser
    localparam logic [REQ_W-1:0] REQ_LOAD_FIRST  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;

    // internal command kinds
    typedef enum logic [1:0] {
        OP_LOAD_FIRST,
        OP_LOAD_SECOND,
        OP_COMPUTE
    } cmd_op_t;

    // one classified command between front and back
    typedef struct packed {
        cmd_op_t                   op;
        logic signed [COEF_W-1:0]  coef;
        logic [EXP_W-1:0]          exponent;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/spa_front.sv
`default_nettype none

module spa_front (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [spa_pkg::IN_TDATA_W-1:0]  s_tdata,   // coefficient, exponent
    input  wire logic [spa_pkg::REQ_W-1:0]       s_tuser,   // req_type
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output spa_pkg::cmd_t                        push_cmd
);
    import spa_pkg::*;

    // take a beat whenever the queue has room
    assign s_tready = push_ready;

    // classify the request; unused code is swallowed here
    always_comb
    begin
        push_cmd.coef     = s_tdata[COEF_W-1:0];
        push_cmd.exponent = s_tdata[COEF_W+EXP_W-1:COEF_W];
        push_cmd.op       = OP_COMPUTE;
        push_valid        = 1'b0;
        unique case (s_tuser)
            REQ_LOAD_FIRST:
            begin
                push_cmd.op = OP_LOAD_FIRST;
                push_valid  = s_tvalid;
            end
            REQ_LOAD_SECOND:
            begin
                push_cmd.op = OP_LOAD_SECOND;
                push_valid  = s_tvalid;
            end
            REQ_COMPUTE:
            begin
                push_cmd.op = OP_COMPUTE;
                push_valid  = s_tvalid;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/spa_cmd_queue.sv
`default_nettype none

module spa_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire spa_pkg::cmd_t  push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output spa_pkg::cmd_t       pop_cmd
);
    import spa_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/spa_merge.sv
`default_nettype none

module spa_merge #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    output logic                                   pop_ready,
    input  wire spa_pkg::cmd_t                     pop_cmd,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [spa_pkg::SUM_W-1:0]       out_coef,
    output logic [spa_pkg::EXP_W-1:0]              out_exp,
    output logic                                   out_last,
    output logic                                   out_overflow
);
    import spa_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TERM_W = COEF_W + EXP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // term stores, coefficient in the low bits
    logic [TERM_W-1:0] mem_a [MAX_TERMS];
    logic [TERM_W-1:0] mem_b [MAX_TERMS];
    logic [TERM_W-1:0] rd_a_reg;
    logic [TERM_W-1:0] rd_b_reg;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_a_reg;
    logic [CNT_W-1:0]        cnt_b_reg;
    logic [CNT_W-1:0]        i_reg;
    logic [CNT_W-1:0]        j_reg;
    logic                    dropped_reg;
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_coef_reg;
    logic [EXP_W-1:0]        out_exp_reg;
    logic                    out_last_reg;
    logic                    out_ovf_reg;

    logic                    take_cmd;
    logic                    wr_a;
    logic                    wr_b;
    logic                    a_has;
    logic                    b_has;
    logic                    take_a;
    logic                    take_b;
    logic [CNT_W-1:0]        i_next;
    logic [CNT_W-1:0]        j_next;
    logic                    emit_done;
    logic                    slot_free;
    logic                    emit_fire;
    logic signed [SUM_W-1:0] coef_a;
    logic signed [SUM_W-1:0] coef_b;
    logic signed [SUM_W-1:0] sum_next;
    logic [EXP_W-1:0]        exp_a;
    logic [EXP_W-1:0]        exp_b;
    logic [EXP_W-1:0]        exp_next;

    assign pop_ready    = (state_reg == ST_IDLE);
    assign take_cmd     = pop_valid && pop_ready;
    assign wr_a         = take_cmd && (pop_cmd.op == OP_LOAD_FIRST) && (cnt_a_reg < CNT_MAX);
    assign wr_b         = take_cmd && (pop_cmd.op == OP_LOAD_SECOND) && (cnt_b_reg < CNT_MAX);
    assign out_valid    = out_valid_reg;
    assign out_coef     = out_coef_reg;
    assign out_exp      = out_exp_reg;
    assign out_last     = out_last_reg;
    assign out_overflow = out_ovf_reg;

    // store write and registered head read
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= {pop_cmd.exponent, pop_cmd.coef};
        end
        if (wr_b)
        begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= {pop_cmd.exponent, pop_cmd.coef};
        end
        rd_a_reg <= mem_a[i_reg[IDX_W-1:0]];
        rd_b_reg <= mem_b[j_reg[IDX_W-1:0]];
    end

    // one merge step on the two fetched heads
    always_comb
    begin
        coef_a = {rd_a_reg[COEF_W-1], rd_a_reg[COEF_W-1:0]};
        coef_b = {rd_b_reg[COEF_W-1], rd_b_reg[COEF_W-1:0]};
        exp_a  = rd_a_reg[TERM_W-1:COEF_W];
        exp_b  = rd_b_reg[TERM_W-1:COEF_W];
        a_has  = (i_reg < cnt_a_reg);
        b_has  = (j_reg < cnt_b_reg);
        if (a_has && b_has)
        begin
            take_a = (exp_a >= exp_b);
            take_b = (exp_b >= exp_a);
        end
        else
        begin
            take_a = a_has;
            take_b = !a_has;
        end
        if (take_a && take_b)
        begin
            sum_next = coef_a + coef_b;
            exp_next = exp_b;
        end
        else if (take_a)
        begin
            sum_next = coef_a;
            exp_next = exp_a;
        end
        else
        begin
            sum_next = coef_b;
            exp_next = exp_b;
        end
        i_next    = i_reg + CNT_W'(take_a);
        j_next    = j_reg + CNT_W'(take_b);
        emit_done = !(i_next < cnt_a_reg) && !(j_next < cnt_b_reg);
        slot_free = !out_valid_reg || out_ready;
        emit_fire = (state_reg == ST_EMIT) && slot_free;
    end

    // sequencer, counts and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_cmd)
                    begin
                        unique case (pop_cmd.op)
                            OP_LOAD_FIRST:
                            begin
                                if (wr_a)
                                begin
                                    cnt_a_reg <= cnt_a_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            OP_LOAD_SECOND:
                            begin
                                if (wr_b)
                                begin
                                    cnt_b_reg <= cnt_b_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            OP_COMPUTE:
                            begin
                                i_reg <= '0;
                                j_reg <= '0;
                                if ((cnt_a_reg == '0) && (cnt_b_reg == '0))
                                begin
                                    dropped_reg <= 1'b0;
                                end
                                else
                                begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_coef_reg  <= sum_next;
                        out_exp_reg   <= exp_next;
                        out_last_reg  <= emit_done;
                        out_ovf_reg   <= dropped_reg;
                        i_reg         <= i_next;
                        j_reg         <= j_next;
                        if (emit_done)
                        begin
                            state_reg   <= ST_IDLE;
                            cnt_a_reg   <= '0;
                            cnt_b_reg   <= '0;
                            dropped_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // a merge step always has at least one live head
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (a_has || b_has))
        else $error("merge step with both stores exhausted");

    // fill counts stay within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CNT_MAX) && (cnt_b_reg <= CNT_MAX))
        else $error("term count beyond capacity");

    // read pointers never pass their counts while merging
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg)))
        else $error("read pointer past fill count");

    // the final term of a run leaves the stores empty and the flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_done) |=>
            ((state_reg == ST_IDLE) && (cnt_a_reg == '0) && (cnt_b_reg == '0)
             && !dropped_reg && out_valid_reg && out_last_reg))
        else $error("run did not close cleanly");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sparse_polynomial_adder.sv
`default_nettype none

// Sparse polynomial adder. Terms of two polynomials are loaded one beat at a
// time (tuser 0 for the first store, 1 for the second, coefficient and
// exponent on tdata), each in descending exponent order; tuser 2 merges the
// two stores and streams the sum terms out, largest exponent first, equal
// exponents summed (zero sums kept), tlast on the final term and tuser set
// when a load was dropped because its store already held MAX_TERMS terms.
// Both stores and the drop flag are empty again after a compute beat; a
// compute with both stores empty gives no output, and tuser 3 is ignored.
// A two-entry command queue sits between the input and the merge engine.
// Each load is taken by the engine in its idle state. A compute leaves idle
// and then, for each result term, does a registered store read and then
// the merge step; the merge step waits while the output is stalled; the
// result register lets the next beat be taken while a finished term waits.
module sparse_polynomial_adder #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [spa_pkg::IN_TDATA_W-1:0]   s_tdata,   // coefficient, exponent
    input  wire logic [spa_pkg::REQ_W-1:0]        s_tuser,   // req_type
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [spa_pkg::OUT_TDATA_W-1:0]       m_tdata,   // sum_coefficient, sum_exponent
    output logic                                  m_tuser,   // overflow_seen
    output logic                                  m_tlast    // last_term
);
    import spa_pkg::*;

    logic                    push_valid;
    logic                    push_ready;
    cmd_t                    push_cmd;
    logic                    pop_valid;
    logic                    pop_ready;
    cmd_t                    pop_cmd;
    logic signed [SUM_W-1:0] out_coef;
    logic [EXP_W-1:0]        out_exp;

    // request decode
    spa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    spa_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // term stores and merge engine
    spa_merge #(
        .MAX_TERMS (MAX_TERMS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_coef     (out_coef),
        .out_exp      (out_exp),
        .out_last     (m_tlast),
        .out_overflow (m_tuser)
    );

    // pack the result beat
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_exp, out_coef};

endmodule

`default_nettype wire
